### src/assert_macros.svh
// Assertion macros shared by the stepper homing sequencer RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever a holds on a clock edge out of reset, c must hold too.
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed: implication");

// Condition must never hold on a clock edge out of reset.
`define ASSERT_NEVER(label, clk, rst_n, a) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(a)) \
        else $error("assertion failed: forbidden condition");

`endif

### src/shsq_pkg.sv
// Package for the stepper homing sequencer: widths, reset values,
// register indexes and the result item type. No dependencies.
package shsq_pkg;

    localparam int MDEG_W      = 16;
    localparam int PERIOD_W    = 16;
    localparam int RATE_W      = 8;
    localparam int COUNT_W     = 16;
    localparam int TARGET_W    = 12;
    localparam int PHASE_W     = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam int MICROSTEPS_DEF = 16;

    // 376 mdeg per full step = 8 * 47
    localparam int DEG_PER_STEP = 376;
    localparam int DEG_SHIFT    = 3;
    localparam int DEG_ODD      = DEG_PER_STEP >> DEG_SHIFT;

    localparam logic [TARGET_W-1:0] TARGET_MAX   = 12'd4095;
    localparam logic [TARGET_W-1:0] TARGET_RST   = 12'd4;
    localparam logic [COUNT_W-1:0]  COUNT_MAX    = 16'hFFFF;

    localparam logic [PERIOD_W-1:0] INIT_PERIOD_RST  = 16'd10000;
    localparam logic [PERIOD_W-1:0] FINAL_PERIOD_RST = 16'd2000;
    localparam logic [PERIOD_W-1:0] START_PERIOD_RST = 16'd1000;
    localparam logic [RATE_W-1:0]   HOME_RATE_RST    = 8'd100;
    localparam logic [RATE_W-1:0]   FIELD_RATE_RST   = 8'd50;
    localparam logic [RATE_W-1:0]   EXTRA_STEPS_RST  = 8'd10;

    localparam logic [CFG_IDX_W-1:0] REG_INIT_PERIOD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FINAL_PERIOD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_PERIOD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOME_RATE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_RATE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_EXTRA_STEPS  = 3'd5;

    typedef struct packed {
        logic                accepted;
        logic                step_pin;
        logic                driver_enabled;
        logic                direction;
        logic                torque_high;
        logic                timer_running;
        logic                period_load;
        logic [PERIOD_W-1:0] period_value;
        logic [PERIOD_W-1:0] ramp_final_period;
        logic [RATE_W-1:0]   ramp_slope;
        logic                at_target;
        logic                busy_res;
    } t_result;

endpackage

### src/shsq_div.sv
// Target conversion: millidegrees to microsteps, mdeg*MICROSTEPS/376,
// saturated to 12 bits. Two stages, reciprocal multiply. Uses shsq_pkg.
module shsq_div
    import shsq_pkg::*;
#(
    parameter int MICROSTEPS = MICROSTEPS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_go,
    input  logic [MDEG_W-1:0]   i_tgt,
    output logic [TARGET_W-1:0] o_target
);

    localparam int PW = MDEG_W + $clog2(MICROSTEPS + 1);
    localparam int XW = PW - DEG_SHIFT;
    localparam int SH = XW + $clog2(DEG_ODD);
    localparam int RW = XW + 1;
    localparam int QW = XW + RW;
    localparam logic [RW-1:0] RECIP = RW'(((64'd1 << SH) + DEG_ODD - 1) / DEG_ODD);

    logic [PW-1:0]    prod;
    logic [XW-1:0]    r_x;
    logic             r_go;
    logic [QW-1:0]    qprod;
    logic [QW-SH-1:0] quot;
    logic [TARGET_W-1:0] r_target;

    assign prod = PW'(i_tgt) * PW'(MICROSTEPS);

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_x <= prod[PW-1:DEG_SHIFT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_go <= 1'b0;
        end else begin
            r_go <= i_go;
        end
    end

    assign qprod = QW'(r_x) * QW'(RECIP);
    assign quot  = qprod[QW-1:SH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= TARGET_RST;
        end else if (r_go) begin
            if (32'(quot) > 32'(TARGET_MAX)) begin
                r_target <= TARGET_MAX;
            end else begin
                r_target <= TARGET_W'(quot);
            end
        end
    end

    assign o_target = r_target;

endmodule

### src/shsq_core.sv
// Sequencer core: configuration registers, phase state and result logic
// for one item per cycle while i_go is high. Uses shsq_pkg.
module shsq_core
    import shsq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_go,
    input  logic                  i_command,
    input  logic                  i_opto_engaged,
    input  logic                  i_driver_latched,
    input  logic [TARGET_W-1:0]   i_target,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_div_go,
    output t_result               o_result
);

    localparam logic [PHASE_W-1:0] PH_HOME      = 3'd0;
    localparam logic [PHASE_W-1:0] PH_LATCH_CCW = 3'd1;
    localparam logic [PHASE_W-1:0] PH_SEEK      = 3'd2;
    localparam logic [PHASE_W-1:0] PH_EXTRA     = 3'd3;
    localparam logic [PHASE_W-1:0] PH_LATCH_CW  = 3'd4;
    localparam logic [PHASE_W-1:0] PH_CLEAR     = 3'd5;
    localparam logic [PHASE_W-1:0] PH_TARGET    = 3'd6;

    logic [PERIOD_W-1:0] r_init_period, r_final_period, r_start_period;
    logic [RATE_W-1:0]   r_home_rate, r_field_rate, r_extra_steps;

    logic [PHASE_W-1:0]  r_phase, n_phase;
    logic [COUNT_W-1:0]  r_step_count, n_step_count;
    logic                r_step_phase, n_step_phase;
    logic                r_busy, n_busy;
    logic                r_valid, n_valid;
    logic                r_drv_on, n_drv_on;
    logic                r_drv_dir, n_drv_dir;
    logic                r_drv_high, n_drv_high;
    logic                r_timer_on, n_timer_on;
    logic [RATE_W-1:0]   r_ramp_held, n_ramp_held;
    logic                r_pin, n_pin;

    logic                acc, load, pulse, done, div_go;
    logic [PERIOD_W-1:0] load_val;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v == COUNT_MAX) ? v : v + COUNT_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_period  <= INIT_PERIOD_RST;
            r_final_period <= FINAL_PERIOD_RST;
            r_start_period <= START_PERIOD_RST;
            r_home_rate    <= HOME_RATE_RST;
            r_field_rate   <= FIELD_RATE_RST;
            r_extra_steps  <= EXTRA_STEPS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_INIT_PERIOD:  r_init_period  <= i_cfg_data;
                REG_FINAL_PERIOD: r_final_period <= i_cfg_data;
                REG_START_PERIOD: r_start_period <= i_cfg_data;
                REG_HOME_RATE:    r_home_rate    <= i_cfg_data[RATE_W-1:0];
                REG_FIELD_RATE:   r_field_rate   <= i_cfg_data[RATE_W-1:0];
                REG_EXTRA_STEPS:  r_extra_steps  <= i_cfg_data[RATE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_step_count = r_step_count;
        n_step_phase = r_step_phase;
        n_busy       = r_busy;
        n_valid      = r_valid;
        n_drv_on     = r_drv_on;
        n_drv_dir    = r_drv_dir;
        n_drv_high   = r_drv_high;
        n_timer_on   = r_timer_on;
        n_ramp_held  = r_ramp_held;
        n_pin        = r_pin;
        acc          = 1'b0;
        load         = 1'b0;
        load_val     = '0;
        pulse        = 1'b0;
        done         = 1'b0;
        div_go       = 1'b0;

        if (i_go) begin
            if (i_command) begin
                if (!r_busy) begin
                    acc        = 1'b1;
                    div_go     = 1'b1;
                    n_busy     = 1'b1;
                    n_phase    = PH_HOME;
                    n_timer_on = 1'b1;
                    load       = 1'b1;
                    load_val   = r_start_period;
                end
            end else if (r_busy) begin
                case (r_phase)
                    PH_HOME: begin
                        n_step_phase = 1'b0;
                        n_ramp_held  = r_home_rate;
                        n_timer_on   = 1'b1;
                        load         = 1'b1;
                        load_val     = r_init_period;
                        n_drv_on     = 1'b1;
                        n_drv_high   = 1'b1;
                        n_drv_dir    = 1'b0;
                        n_phase      = PH_LATCH_CCW;
                        n_step_count = '0;
                    end
                    PH_LATCH_CCW: begin
                        if (i_driver_latched) begin
                            n_phase = PH_SEEK;
                        end
                    end
                    PH_SEEK: begin
                        n_step_count = sat_inc(r_step_count);
                        if (i_opto_engaged) begin
                            n_step_count = '0;
                            n_phase      = PH_EXTRA;
                        end else begin
                            pulse = 1'b1;
                        end
                    end
                    PH_EXTRA: begin
                        if (r_step_count >= COUNT_W'(r_extra_steps)) begin
                            n_drv_on    = 1'b1;
                            n_drv_high  = 1'b1;
                            n_drv_dir   = 1'b1;
                            n_ramp_held = r_field_rate;
                            load        = 1'b1;
                            load_val    = r_init_period;
                            n_phase     = PH_LATCH_CW;
                        end else begin
                            pulse = 1'b1;
                        end
                    end
                    PH_LATCH_CW: begin
                        if (i_driver_latched) begin
                            n_step_count = '0;
                            n_phase      = PH_CLEAR;
                        end
                    end
                    PH_CLEAR: begin
                        if (!i_opto_engaged) begin
                            n_step_count = '0;
                            n_phase      = PH_TARGET;
                        end
                        pulse = 1'b1;
                    end
                    PH_TARGET: begin
                        if (r_step_count >= COUNT_W'(i_target)) begin
                            done = 1'b1;
                        end else begin
                            pulse = 1'b1;
                        end
                    end
                    default: ;
                endcase

                if (done) begin
                    n_pin        = 1'b0;
                    n_step_phase = 1'b0;
                    n_drv_on     = 1'b1;
                    n_drv_high   = 1'b0;
                    n_drv_dir    = 1'b1;
                    n_timer_on   = 1'b0;
                    n_busy       = 1'b0;
                    n_valid      = 1'b1;
                end else if (pulse) begin
                    n_pin = n_step_phase;
                    if (n_step_phase) begin
                        n_step_count = sat_inc(n_step_count);
                    end
                    n_step_phase = !n_step_phase;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HOME;
            r_step_count <= '0;
            r_step_phase <= 1'b0;
            r_busy       <= 1'b0;
            r_valid      <= 1'b0;
            r_drv_on     <= 1'b0;
            r_drv_dir    <= 1'b0;
            r_drv_high   <= 1'b1;
            r_timer_on   <= 1'b0;
            r_ramp_held  <= '0;
            r_pin        <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_step_count <= n_step_count;
            r_step_phase <= n_step_phase;
            r_busy       <= n_busy;
            r_valid      <= n_valid;
            r_drv_on     <= n_drv_on;
            r_drv_dir    <= n_drv_dir;
            r_drv_high   <= n_drv_high;
            r_timer_on   <= n_timer_on;
            r_ramp_held  <= n_ramp_held;
            r_pin        <= n_pin;
        end
    end

    assign o_div_go = div_go;

    always_comb begin
        o_result.accepted          = acc;
        o_result.step_pin          = n_pin;
        o_result.driver_enabled    = n_drv_on;
        o_result.direction         = n_drv_dir;
        o_result.torque_high       = n_drv_high;
        o_result.timer_running     = n_timer_on;
        o_result.period_load       = load;
        o_result.period_value      = load_val;
        o_result.ramp_final_period = r_final_period;
        o_result.ramp_slope        = n_ramp_held;
        o_result.at_target         = n_valid;
        o_result.busy_res          = n_busy;
    end

endmodule

### src/shsq_outq.sv
// Two-entry result queue that decouples the core from the receiver.
// Uses shsq_pkg for the result item type.
module shsq_outq
    import shsq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_space,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    t_result     r_mem [2];
    logic        r_wptr, r_rptr;
    logic [1:0]  r_count;
    logic        pop;

    assign pop     = (r_count != 2'd0) && i_ready;
    assign o_space = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (pop) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(pop);
        end
    end

endmodule

### src/stepper_homing_sequencer_unit.sv
// Stepper homing sequencer, top level: input register, core, target
// conversion and result queue. Uses shsq_pkg, shsq_div, shsq_core, shsq_outq.
//
// Usage:
// Input channel (i_valid/o_ready) carries one item: a timer tick or a start
// command with a target angle and the sensor/driver levels. Output channel
// (o_valid/i_ready) returns exactly one result item per input item, in order.
// Each item is registered on acceptance, processed by the core and written
// into a two-entry result queue, which presents it to the receiver.
// Throughput is one item per cycle while the result queue has space. The
// target conversion (mdeg*MICROSTEPS/376) runs in its own pipeline (r_x,
// then r_target); its value is only needed in the last homing phase. When the
// receiver stalls, the queue absorbs up to two results plus one in the input
// register before o_ready drops. Reset is synchronous, active low: control
// state clears (torque high sets), registers take their default values, and
// the target defaults to 4 microsteps. Configuration writes (i_cfg_we) take
// effect at once and are only to be issued while the block is idle.
module stepper_homing_sequencer_unit
    import shsq_pkg::*;
#(
    parameter int MICROSTEPS = MICROSTEPS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_command,
    input  logic [MDEG_W-1:0]     i_target_mdeg,
    input  logic                  i_opto_engaged,
    input  logic                  i_driver_latched,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_accepted,
    output logic                  o_step_pin,
    output logic                  o_driver_enabled,
    output logic                  o_direction,
    output logic                  o_torque_high,
    output logic                  o_timer_running,
    output logic                  o_period_load,
    output logic [PERIOD_W-1:0]   o_period_value,
    output logic [PERIOD_W-1:0]   o_ramp_final_period,
    output logic [RATE_W-1:0]     o_ramp_slope,
    output logic                  o_at_target,
    output logic                  o_busy_res
);

`include "assert_macros.svh"

    logic              r_in_valid;
    logic              r_command, r_opto, r_latched;
    logic [MDEG_W-1:0] r_tgt;
    logic              core_go, q_space, div_go;
    logic [TARGET_W-1:0] target;
    t_result           core_res, q_res;

    assign core_go = r_in_valid && q_space;
    assign o_ready = !r_in_valid || core_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_command <= i_command;
            r_tgt     <= i_target_mdeg;
            r_opto    <= i_opto_engaged;
            r_latched <= i_driver_latched;
        end
    end

    shsq_div #(
        .MICROSTEPS(MICROSTEPS)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (div_go),
        .i_tgt    (r_tgt),
        .o_target (target)
    );

    shsq_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_go             (core_go),
        .i_command        (r_command),
        .i_opto_engaged   (r_opto),
        .i_driver_latched (r_latched),
        .i_target         (target),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_div_go         (div_go),
        .o_result         (core_res)
    );

    shsq_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (core_go),
        .i_data  (core_res),
        .o_space (q_space),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (q_res)
    );

    assign o_accepted          = q_res.accepted;
    assign o_step_pin          = q_res.step_pin;
    assign o_driver_enabled    = q_res.driver_enabled;
    assign o_direction         = q_res.direction;
    assign o_torque_high       = q_res.torque_high;
    assign o_timer_running     = q_res.timer_running;
    assign o_period_load       = q_res.period_load;
    assign o_period_value      = q_res.period_value;
    assign o_ramp_final_period = q_res.ramp_final_period;
    assign o_ramp_slope        = q_res.ramp_slope;
    assign o_at_target         = q_res.at_target;
    assign o_busy_res          = q_res.busy_res;

    `ASSERT_IMPLIES(a_accept_starts, i_clk, i_rst_n, o_valid && o_accepted, o_busy_res && o_timer_running && o_period_load)
    `ASSERT_IMPLIES(a_timer_tracks_busy, i_clk, i_rst_n, o_valid, o_timer_running == o_busy_res)
    `ASSERT_IMPLIES(a_done_medium_torque, i_clk, i_rst_n, o_valid && o_at_target && !o_busy_res, !o_torque_high && o_direction)
    `ASSERT_NEVER(a_period_without_load, i_clk, i_rst_n, o_valid && !o_period_load && (o_period_value != 16'd0))

endmodule
